// ----- sv/wff_pkg.sv -----
// wff_pkg: shared types and constants for the worst-fit free-block allocator
// holds table entry layout, status codes, fsm states and the ctrl/datapath
// command and status structs; no dependencies
package wff_pkg;

  localparam int START_W = 24;
  localparam int LEN_W   = 16;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOFIT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD,
    S_POP,
    S_INS_START,
    S_WALK,
    S_PUT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_ONE,
    RA_CNT_M1,
    RA_IDX_P1,
    RA_IDX_M2
  } rd_sel_t;

  typedef enum logic {
    WA_IDX,
    WA_IDX_M1
  } wa_sel_t;

  typedef enum logic {
    WD_NEW,
    WD_RD
  } wd_sel_t;

  typedef enum logic [2:0] {
    IX_HOLD,
    IX_COUNT,
    IX_ONE,
    IX_INC,
    IX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CN_HOLD,
    CN_INC,
    CN_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    latch_in;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    head_take;
    logic    res_load;
    status_t res_code;
    logic    grant_load;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic new_zero;
    logic full;
    logic empty;
    logic count_one;
    logic rd_less;
    logic rd_equal;
    logic idx_one;
    logic pop_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- sv/wff_dp.sv -----
// wff_dp: datapath of the allocator - table memory, entry count, walk index,
// working entry, result and output registers
// depends on wff_pkg; driven by commands from wff_ctrl
module wff_dp
  import wff_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               opcode,
  input  logic [START_W-1:0] block_start,
  input  logic [LEN_W-1:0]   block_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [START_W-1:0] granted_start
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  entry_t new_e;
  logic   op_alloc;

  logic [CW-1:0] count;
  logic [AW-1:0] idx;

  status_t            res_status;
  logic [START_W-1:0] res_granted;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  always_comb begin
    case (cmd.rd_sel)
      RA_ZERO:   rd_addr = '0;
      RA_ONE:    rd_addr = AW'(1);
      RA_CNT_M1: rd_addr = AW'(count - CW'(1));
      RA_IDX_P1: rd_addr = idx + AW'(1);
      RA_IDX_M2: rd_addr = idx - AW'(2);
      default:   rd_addr = '0;
    endcase
  end

  assign wr_addr = (cmd.wa_sel == WA_IDX_M1) ? (idx - AW'(1)) : idx;
  assign wr_data = (cmd.wd_sel == WD_RD) ? rd_q : new_e;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CN_INC:  count <= count + CW'(1);
        CN_DEC:  count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      IX_COUNT: idx <= AW'(count);
      IX_ONE:   idx <= AW'(1);
      IX_INC:   idx <= idx + AW'(1);
      IX_DEC:   idx <= idx - AW'(1);
      default:  idx <= idx;
    endcase
  end

  // working entry: request on entry, remainder after the head is granted
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_alloc    <= opcode;
      new_e.start <= block_start;
      new_e.len   <= block_length;
    end else if (cmd.head_take) begin
      new_e.start <= rd_q.start + START_W'(new_e.len);
      new_e.len   <= rd_q.len - new_e.len;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status  <= cmd.res_code;
      res_granted <= cmd.grant_load ? rd_q.start : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status        <= res_status;
      granted_start <= res_granted;
    end
  end

  always_comb begin
    sts.is_alloc  = op_alloc;
    sts.new_zero  = (new_e.len == '0);
    sts.full      = (count == CW'(TABLE_DEPTH));
    sts.empty     = (count == '0);
    sts.count_one = (count == CW'(1));
    sts.rd_less   = (rd_q.len < new_e.len);
    sts.rd_equal  = (rd_q.len == new_e.len);
    sts.idx_one   = (idx == AW'(1));
    sts.pop_last  = ((CW'(idx) + CW'(1)) >= count);
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule

// ----- sv/wff_ctrl.sv -----
// wff_ctrl: sequencer for free, allocate, head pop and sorted insert walks
// depends on wff_pkg; issues commands to wff_dp and reads its status
module wff_ctrl
  import wff_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd.res_load = 1'b1;
        cmd.res_code = ST_OK;
        if (!sts.is_alloc) begin
          if (sts.new_zero) begin
            state_next = S_DONE;
          end else if (sts.full) begin
            cmd.res_code = ST_FULL;
            state_next   = S_DONE;
          end else begin
            state_next = S_INS_START;
          end
        end else if (sts.empty) begin
          cmd.res_code = ST_EMPTY;
          state_next   = S_DONE;
        end else begin
          cmd.rd_sel = RA_ZERO;
          state_next = S_HEAD;
        end
      end

      // head entry is on the read port
      S_HEAD: begin
        if (sts.rd_less) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOFIT;
          state_next   = S_DONE;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = ST_OK;
          cmd.grant_load = 1'b1;
          cmd.head_take  = 1'b1;
          if (sts.count_one) begin
            cmd.cnt_op = CN_DEC;
            state_next = sts.rd_equal ? S_DONE : S_INS_START;
          end else begin
            cmd.idx_op = IX_ONE;
            cmd.rd_sel = RA_ONE;
            state_next = S_POP;
          end
        end
      end

      // move entry idx down to idx-1
      S_POP: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_IDX_M1;
        cmd.wd_sel = WD_RD;
        if (sts.pop_last) begin
          cmd.cnt_op = CN_DEC;
          state_next = sts.new_zero ? S_DONE : S_INS_START;
        end else begin
          cmd.idx_op = IX_INC;
          cmd.rd_sel = RA_IDX_P1;
        end
      end

      S_INS_START: begin
        cmd.idx_op = IX_COUNT;
        if (sts.empty) begin
          state_next = S_PUT;
        end else begin
          cmd.rd_sel = RA_CNT_M1;
          state_next = S_WALK;
        end
      end

      // entry idx-1 is on the read port; shift it up while shorter than new
      S_WALK: begin
        cmd.wr_en = 1'b1;
        if (sts.rd_less) begin
          cmd.wa_sel = WA_IDX;
          cmd.wd_sel = WD_RD;
          cmd.idx_op = IX_DEC;
          if (sts.idx_one) begin
            state_next = S_PUT;
          end else begin
            cmd.rd_sel = RA_IDX_M2;
          end
        end else begin
          cmd.wa_sel = WA_IDX;
          cmd.wd_sel = WD_NEW;
          cmd.cnt_op = CN_INC;
          state_next = S_DONE;
        end
      end

      S_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_IDX;
        cmd.wd_sel = WD_NEW;
        cmd.cnt_op = CN_INC;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/worst_fit_free_list_allocator.sv -----
// worst_fit_free_list_allocator: top level of the worst-fit free-block table
// depends on wff_pkg, wff_ctrl and wff_dp
//
// Usage: the input channel (in_valid/in_ready) carries one request per beat:
// opcode 0 frees a block (block_start, block_length), opcode 1 allocates
// block_length from the largest free block. Every request yields exactly one
// beat on the output channel (out_valid/out_ready) with status (ok, table
// empty, no fit, table full) and granted_start (nonzero only on a granted
// allocate). The table is held sorted by length, largest first.
// One request is worked on at a time. The table sits in a memory with one
// read and one write port that is walked one entry per cycle. A free that
// is dropped or of zero length and an allocate on an empty table go from
// decode straight to the result; a stored free walks the table for its
// insert, and an allocate may walk it for the head pop and again to
// reinsert the remainder. The input is ready again in the cycle after the
// result is loaded.
// The result sits in an output register; while the receiver stalls, the next
// request may finish its work but is held in the result register meanwhile.
// Reset empties the table (entry count to zero) and drops any pending output;
// memory contents need no clearing since only counted entries are read.
module worst_fit_free_list_allocator
  import wff_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [START_W-1:0] block_start,
  input  logic [LEN_W-1:0]   block_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [START_W-1:0] granted_start
);

  cmd_t cmd;
  sts_t sts;

  wff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wff_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .block_start   (block_start),
    .block_length  (block_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_start (granted_start)
  );

  // one request at a time: no new beat right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a request is in progress");

  // the table is never written while waiting for a request
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.wr_en)
    else $error("table write while idle");

  // a result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten while stalled");

  // a full table never takes an insert
  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    sts.full |-> (cmd.cnt_op != CN_INC))
    else $error("entry count grows past the table depth");

endmodule

// ----- verif/wff_tb_pkg.sv -----
// wff_tb_pkg: request opcodes shared by the allocator testbench files
// no dependencies
package wff_tb_pkg;

  typedef enum logic {
    OP_FREE  = 1'b0,
    OP_ALLOC = 1'b1
  } req_op_t;

endpackage

// ----- verif/wff_grant_checker.sv -----
// wff_grant_checker: watches both channels of the worst-fit allocator, keeps a
// sorted free-block table of its own and compares every result beat with it
// depends on wff_pkg and wff_tb_pkg
module wff_grant_checker
  import wff_pkg::*;
  import wff_tb_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               opcode,
  input  logic [START_W-1:0] block_start,
  input  logic [LEN_W-1:0]   block_length,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [START_W-1:0] granted_start,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            code;
    logic [START_W-1:0] start;
  } outcome_t;

  entry_t      free_tab [TABLE_DEPTH];
  int unsigned used;
  outcome_t    outcome_q [$];
  int          results_seen;

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 30) begin
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
    end
  endtask

  // sorted insert behind every entry of equal or larger length
  function automatic bit table_put(logic [START_W-1:0] s, logic [LEN_W-1:0] l);
    int unsigned slot;
    if (used >= TABLE_DEPTH) return 1'b0;
    slot = 0;
    while (slot < used && free_tab[slot].len >= l) slot++;
    for (int unsigned k = used; k > slot; k--) free_tab[k] = free_tab[k-1];
    free_tab[slot].start = s;
    free_tab[slot].len   = l;
    used++;
    return 1'b1;
  endfunction

  function automatic void table_take_head();
    for (int unsigned k = 1; k < used; k++) free_tab[k-1] = free_tab[k];
    if (used > 0) used--;
  endfunction

  function automatic outcome_t serve_request(req_op_t op, logic [START_W-1:0] s,
                                             logic [LEN_W-1:0] l);
    outcome_t           r;
    entry_t             head;
    logic [START_W-1:0] rest_start;
    logic [LEN_W-1:0]   rest_len;
    r.code  = ST_OK;
    r.start = '0;
    if (op == OP_FREE) begin
      if (l != 0 && !table_put(s, l)) r.code = ST_FULL;
    end else if (used == 0) begin
      r.code = ST_EMPTY;
    end else if (free_tab[0].len < l) begin
      r.code = ST_NOFIT;
    end else begin
      head       = free_tab[0];
      r.start    = head.start;
      rest_start = head.start + START_W'(l);  // wraps at the top of the space
      rest_len   = head.len - l;
      table_take_head();
      if (rest_len != 0) void'(table_put(rest_start, rest_len));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      outcome_q.delete();
      used = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.code) begin
            report_mismatch($sformatf("status %0d, expected %0d", status, want.code));
          end
          if (granted_start !== want.start) begin
            report_mismatch($sformatf("granted_start %06h, expected %06h",
                                      granted_start, want.start));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        outcome_q.insert(outcome_q.size(),
                         serve_request(req_op_t'(opcode), block_start, block_length));
      end
      pending <= outcome_q.size();
    end
  end

endmodule

// ----- verif/tb_worst_fit_free_list_allocator.sv -----
// tb_worst_fit_free_list_allocator: clock, reset and request stimulus for the
// worst-fit allocator, with random stalls on both channels; checking is done
// by wff_grant_checker. depends on wff_pkg, wff_tb_pkg and the block
module tb_worst_fit_free_list_allocator;
  import wff_pkg::*;
  import wff_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1780;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               opcode;
  logic [START_W-1:0] block_start;
  logic [LEN_W-1:0]   block_length;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [START_W-1:0] granted_start;
  int                 fail_count;
  int                 pending;
  bit                 tx_burst;

  worst_fit_free_list_allocator #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .block_start  (block_start),
    .block_length (block_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_start(granted_start)
  );

  wff_grant_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .block_start  (block_start),
    .block_length (block_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_start(granted_start),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one request beat; settle first waits until every result is back
  task automatic issue_request(req_op_t op, logic [START_W-1:0] s, logic [LEN_W-1:0] l,
                               bit settle);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (settle || gap > 0) begin
      in_valid <= 1'b0;
      if (settle) begin
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    block_start  <= s;
    block_length <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver: random stall after each beat, two long hold-offs to back up the block
  initial begin : rx_side
    int  stall;
    int  beats;
    bit  rx_burst;
    stall     = 0;
    beats     = 0;
    rx_burst  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        beats++;
        if (beats % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        if (beats == 300 || beats == 1100) stall = 600;
        else stall = rx_burst ? 0 : $urandom_range(0, 18);
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  initial begin : tx_side
    req_op_t            op;
    logic [START_W-1:0] s;
    logic [LEN_W-1:0]   l;
    int                 alloc_pct;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    opcode       <= OP_FREE;
    block_start  <= '0;
    block_length <= '0;
    tx_burst     = 1'b0;
    alloc_pct    = 50;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, equal lengths, exact fit, no fit,
    // zero-length requests, start wrap, then fill past full
    issue_request(OP_ALLOC, 24'h000000, 16'd5,     1'b0);
    issue_request(OP_FREE,  24'h000000, 16'hFFFF,  1'b0);
    issue_request(OP_FREE,  24'hFFFFFF, 16'd1,     1'b0);
    issue_request(OP_FREE,  24'h123456, 16'd0,     1'b0);
    issue_request(OP_FREE,  24'h000100, 16'd100,   1'b0);
    issue_request(OP_FREE,  24'h000200, 16'd100,   1'b0);
    issue_request(OP_ALLOC, 24'hABCDEF, 16'hFFFF,  1'b0);
    issue_request(OP_ALLOC, 24'h000000, 16'd101,   1'b0);
    issue_request(OP_ALLOC, 24'h000000, 16'd0,     1'b0);
    issue_request(OP_ALLOC, 24'hFFFFFF, 16'd40,    1'b0);
    issue_request(OP_FREE,  24'hFFFFF0, 16'd200,   1'b0);
    issue_request(OP_ALLOC, 24'h000000, 16'd32,    1'b0);
    for (int n = 0; n < 13; n++) begin
      issue_request(OP_FREE, START_W'($urandom()), LEN_W'($urandom_range(1, 200)), 1'b0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       alloc_pct = 20;
          1:       alloc_pct = 50;
          default: alloc_pct = 80;
        endcase
        tx_burst = ($urandom_range(0, 3) == 0);
      end
      op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      // small lengths give equal entries and exact fits
      case ($urandom_range(0, 19))
        0:                      l = '0;
        1, 2:                   l = '1;
        3, 4, 5, 6, 7, 8, 9, 10: l = LEN_W'($urandom_range(1, 8));
        11, 12, 13, 14, 15:     l = LEN_W'($urandom_range(1, 1000));
        default:                l = LEN_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 5))
        0:       s = START_W'($urandom_range(24'hFFFF00, 24'hFFFFFF));
        1:       s = START_W'($urandom_range(0, 255));
        default: s = START_W'($urandom());
      endcase
      issue_request(op, s, l, (n == 0 || n == 600 || n == 1300));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/wff_pkg.sv
sv/wff_dp.sv
sv/wff_ctrl.sv
sv/worst_fit_free_list_allocator.sv
verif/wff_tb_pkg.sv
verif/wff_grant_checker.sv
verif/tb_worst_fit_free_list_allocator.sv
